FILE: hdl/wvd_pkg.sv
// ----------------------------------------------------------------------------
// wvd_pkg
// Shared types and constants of the windowed vertex dedup block.
// ----------------------------------------------------------------------------
package wvd_pkg;

	localparam int WINDOW_DEPTH_DEF = 64;
	localparam int COORD_WIDTH_DEF  = 32;
	localparam int INDEX_W          = 31;
	localparam int THRESH_W         = 63;
	localparam int WINDOW_W         = 7;
	localparam int CFG_INDEX_W      = 2;
	// Sum of four squared differences needs two bits above the product width.
	localparam int SUM_W            = 66;

	localparam logic [INDEX_W-1:0] INDEX_MAX = {INDEX_W{1'b1}};

	localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_SIZE = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD   = 2'd1;

	typedef struct packed {
		logic signed [31:0] a_x;
		logic signed [31:0] a_y;
		logic signed [31:0] a_z;
		logic signed [31:0] a_w;
		logic signed [31:0] b_x;
		logic signed [31:0] b_y;
		logic signed [31:0] b_z;
		logic signed [31:0] b_w;
		logic signed [31:0] c_x;
		logic signed [31:0] c_y;
		logic signed [31:0] c_z;
		logic signed [31:0] c_w;
	} tri_t;

	typedef struct packed {
		logic [INDEX_W-1:0] first_index;
		logic [INDEX_W-1:0] second_index;
		logic [INDEX_W-1:0] third_index;
		logic [2:0]         appended_mask;
		logic               count_overflow;
	} idx_t;

	// Tag that travels with one stored vertex through the lanes.
	typedef struct packed {
		logic               vld;
		logic [INDEX_W-1:0] gidx;
	} tag_t;

endpackage

FILE: hdl/windowed_vertex_dedup.sv
// Each accepted triangle is searched against n stored vertices, where n is
// min(window_size, WINDOW_DEPTH, vertices stored so far); one stored vertex per
// cycle passes through the single ring read port. A new triangle is taken only
// once the block is back in idle after issuing the previous result.
// Reset clears the ring head, the vertex count and the control state at once;
// the ring contents are not cleared and no unwritten entry is ever searched.
// ----------------------------------------------------------------------------
// windowed_vertex_dedup
// Merges triangle corners with recently stored vertices, three lanes wide.
// ----------------------------------------------------------------------------
module windowed_vertex_dedup import wvd_pkg::*; #(
	parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
	parameter int COORD_WIDTH  = COORD_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   tri_valid,
	output logic                   tri_stall,
	input  tri_t                   tri_data,
	output logic                   idx_valid,
	input  logic                   idx_stall,
	output idx_t                   idx_data,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [THRESH_W-1:0]    cfg_data
);

	localparam int CW = COORD_WIDTH;
	localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int NW = $clog2(WINDOW_DEPTH + 1);
	localparam logic [AW-1:0] LAST_SLOT = AW'(WINDOW_DEPTH - 1);

	typedef enum logic [2:0] {
		S_IDLE, S_SEARCH, S_DRAIN, S_RESOLVE, S_APPEND, S_DONE
	} state_t;

	state_t              state_q;
	logic [WINDOW_W-1:0] window_q;
	logic [THRESH_W-1:0] thresh_q;
	logic [AW-1:0]       head_q;
	logic [INDEX_W-1:0]  stored_q;
	logic [AW-1:0]       addr_q;
	logic [NW-1:0]       cnt_q;
	logic [NW-1:0]       n_q;
	logic [INDEX_W-1:0]  gidx_q;
	logic [1:0]          drain_q;
	logic [1:0]          ap_q;
	logic [2:0]          found_q;
	logic [2:0]          mask_q;
	logic                ovf_q;
	logic [INDEX_W-1:0]  idx_q [3];
	logic [4*CW-1:0]     corner_q [3];

	logic [4*CW-1:0]     mem [WINDOW_DEPTH];
	logic [4*CW-1:0]     rd_s0;
	tag_t                tag_s0;

	tag_t                lane_tag [3];
	logic [2:0]          lane_hit;

	logic [31:0]         coord [12];
	logic [31:0]         lim32, n32, slot32;
	logic [4*CW-1:0]     in_corner [3];
	logic [2:0]          res_found;
	logic                wr_en;

	assign tri_stall = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;

	// Unpack the request into three corners of COORD_WIDTH-bit coordinates.
	always_comb begin
		coord = '{tri_data.a_x, tri_data.a_y, tri_data.a_z, tri_data.a_w,
			tri_data.b_x, tri_data.b_y, tri_data.b_z, tri_data.b_w,
			tri_data.c_x, tri_data.c_y, tri_data.c_z, tri_data.c_w};
		for (int c = 0; c < 3; c++) begin
			for (int k = 0; k < 4; k++) begin
				in_corner[c][k*CW +: CW] = coord[c*4+k][CW-1:0];
			end
		end
	end

	// Search length and the oldest slot of the window.
	always_comb begin
		lim32  = (32'(window_q) < 32'(WINDOW_DEPTH)) ? 32'(window_q) : 32'(WINDOW_DEPTH);
		n32    = (lim32 < 32'(stored_q)) ? lim32 : 32'(stored_q);
		slot32 = (32'(head_q) >= n32) ? (32'(head_q) - n32)
			: (32'(head_q) + 32'(WINDOW_DEPTH) - n32);
	end

	// Tie resolution on the lane results.
	always_comb begin
		res_found = found_q;
		if (res_found[0] && res_found[1] && idx_q[0] == idx_q[1]) begin
			res_found[1] = 1'b0;
		end
		if (res_found[1] && res_found[2] && idx_q[1] == idx_q[2]) begin
			res_found[2] = 1'b0;
		end
		if (res_found[0] && res_found[2] && idx_q[0] == idx_q[2]) begin
			res_found[2] = 1'b0;
		end
	end

	assign wr_en = (state_q == S_APPEND) && !found_q[ap_q] && (stored_q != INDEX_MAX);

	// Vertex ring: one write per appended corner in the append phase, one registered read in search.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[head_q] <= corner_q[ap_q];
		end
		rd_s0 <= mem[addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s0 <= '0;
		end else begin
			tag_s0.vld  <= (state_q == S_SEARCH);
			tag_s0.gidx <= gidx_q;
		end
	end

	// Three lanes, one per corner.
	for (genvar c = 0; c < 3; c++) begin : g_lane
		wvd_lane #(.COORD_WIDTH(COORD_WIDTH)) u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.tag_in   (tag_s0),
			.corner   (corner_q[c]),
			.vertex   (rd_s0),
			.threshold(thresh_q),
			.tag_out  (lane_tag[c]),
			.hit      (lane_hit[c])
		);
	end

	// Corner capture.
	always_ff @(posedge clk) begin
		if (tri_valid && !tri_stall) begin
			corner_q <= in_corner;
		end
	end

	// Sequencer, configuration, merge of lane hits and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			window_q  <= WINDOW_W'(64);
			thresh_q  <= THRESH_W'(1);
			head_q    <= '0;
			stored_q  <= '0;
			addr_q    <= '0;
			cnt_q     <= '0;
			n_q       <= '0;
			gidx_q    <= '0;
			drain_q   <= '0;
			ap_q      <= '0;
			found_q   <= '0;
			mask_q    <= '0;
			ovf_q     <= 1'b0;
			idx_q     <= '{default: '0};
			idx_valid <= 1'b0;
			idx_data  <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_WINDOW_SIZE: window_q <= cfg_data[WINDOW_W-1:0];
					CFG_THRESHOLD:   thresh_q <= cfg_data;
					default:         ;
				endcase
			end
			if (idx_valid && !idx_stall && state_q != S_DONE) begin
				idx_valid <= 1'b0;
			end
			// Oldest-first hits: the first one per lane wins.
			for (int c = 0; c < 3; c++) begin
				if (lane_tag[c].vld && lane_hit[c] && !found_q[c]) begin
					found_q[c] <= 1'b1;
					idx_q[c]   <= lane_tag[c].gidx;
				end
			end
			case (state_q)
				S_IDLE: begin
					if (tri_valid) begin
						found_q <= '0;
						mask_q  <= '0;
						ovf_q   <= 1'b0;
						n_q     <= NW'(n32);
						cnt_q   <= '0;
						addr_q  <= AW'(slot32);
						gidx_q  <= stored_q - INDEX_W'(n32) + INDEX_W'(1);
						drain_q <= '0;
						state_q <= (n32 != 32'd0) ? S_SEARCH : S_RESOLVE;
					end
				end
				S_SEARCH: begin
					addr_q <= (addr_q == LAST_SLOT) ? '0 : addr_q + AW'(1);
					gidx_q <= gidx_q + INDEX_W'(1);
					cnt_q  <= cnt_q + NW'(1);
					if (cnt_q == n_q - NW'(1)) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					drain_q <= drain_q + 2'd1;
					if (drain_q == 2'd3) begin
						state_q <= S_RESOLVE;
					end
				end
				S_RESOLVE: begin
					found_q <= res_found;
					ap_q    <= '0;
					state_q <= S_APPEND;
				end
				S_APPEND: begin
					if (!found_q[ap_q]) begin
						mask_q[ap_q] <= 1'b1;
						if (stored_q == INDEX_MAX) begin
							idx_q[ap_q] <= INDEX_MAX;
							ovf_q       <= 1'b1;
						end else begin
							idx_q[ap_q] <= stored_q + INDEX_W'(1);
							stored_q    <= stored_q + INDEX_W'(1);
							head_q      <= (head_q == LAST_SLOT) ? '0 : head_q + AW'(1);
						end
					end
					ap_q <= ap_q + 2'd1;
					if (ap_q == 2'd2) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!idx_valid || !idx_stall) begin
						idx_valid               <= 1'b1;
						idx_data.first_index    <= idx_q[0];
						idx_data.second_index   <= idx_q[1];
						idx_data.third_index    <= idx_q[2];
						idx_data.appended_mask  <= mask_q;
						idx_data.count_overflow <= ovf_q;
						state_q                 <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_stored_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> stored_q >= $past(stored_q))
		else $error("vertex count went backwards");
	a_lane_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		lane_tag[0].vld |-> (state_q == S_SEARCH || state_q == S_DRAIN))
		else $error("lane result outside the search phase");
	a_search_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SEARCH |-> (cnt_q < n_q && 32'(n_q) <= 32'(stored_q)))
		else $error("search ran past the stored vertices");
	a_index_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		idx_valid |-> (idx_data.first_index != '0 && idx_data.second_index != '0
			&& idx_data.third_index != '0))
		else $error("result carries a zero index");
`endif

endmodule

FILE: hdl/wvd_lane.sv
// ----------------------------------------------------------------------------
// wvd_lane
// One corner against one stored vertex: squared distance and threshold test.
// ----------------------------------------------------------------------------
module wvd_lane import wvd_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  tag_t                     tag_in,
	input  logic [4*COORD_WIDTH-1:0] corner,
	input  logic [4*COORD_WIDTH-1:0] vertex,
	input  logic [THRESH_W-1:0]      threshold,
	output tag_t                     tag_out,
	output logic                     hit
);

	localparam int CW = COORD_WIDTH;
	localparam int PW = 2 * CW + 1;

	logic [CW-1:0]   mag_s1 [4];
	logic [2*CW-1:0] prod_s2 [4];
	logic [PW-1:0]   pair_s3 [2];
	tag_t            tag_s1, tag_s2, tag_s3;

	logic [CW:0]     diff [4];
	logic [SUM_W-1:0] total;
	logic [63:0]     sat;

	// Component differences, sign extended by one bit.
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			diff[k] = {corner[k*CW+CW-1], corner[k*CW +: CW]}
				- {vertex[k*CW+CW-1], vertex[k*CW +: CW]};
		end
	end

	// Tags follow the data through the three stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
		end else begin
			tag_s1 <= tag_in;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
		end
	end

	// Magnitude, square, then pairwise sums.
	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			mag_s1[k]  <= diff[k][CW] ? CW'(-diff[k]) : diff[k][CW-1:0];
			prod_s2[k] <= mag_s1[k] * mag_s1[k];
		end
		pair_s3[0] <= PW'(prod_s2[0]) + PW'(prod_s2[1]);
		pair_s3[1] <= PW'(prod_s2[2]) + PW'(prod_s2[3]);
	end

	// Final sum saturates at the 64-bit ceiling before the strict compare.
	always_comb begin
		total = SUM_W'(pair_s3[0]) + SUM_W'(pair_s3[1]);
		sat   = (|total[SUM_W-1:64]) ? {64{1'b1}} : total[63:0];
		hit   = sat < {1'b0, threshold};
	end

	assign tag_out = tag_s3;

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the windowed vertex dedup block. A directed table
// covers reset behavior, window and threshold extremes, tie resolution and
// distance saturation; random triangles built from recently used vertices
// then exercise merging under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb;
	import wvd_pkg::*;

	localparam int DEPTH       = 64;
	localparam int RANDOM_TRIS = 1330;
	localparam int CYCLE_LIMIT = 1000000;

	typedef logic signed [31:0] coord_t;
	typedef coord_t vert_t [4];

	// One directed row: triangle, optional typed-in result.
	typedef struct {
		tri_t tri_in;
		logic has_expect;
		idx_t want;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic tri_valid;
	logic tri_stall;
	tri_t tri_data;
	logic idx_valid;
	logic idx_stall;
	idx_t idx_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [THRESH_W-1:0] cfg_data;

	// Predictor state.
	logic signed [31:0] ring_mem [DEPTH][4];
	int unsigned head_slot;
	logic [30:0] vert_count;
	logic [6:0] win_reg;
	logic [62:0] thresh_reg;

	idx_t expected_q [$];
	vert_t recent_pool [$];
	int errors;
	int checked;
	int merges;
	longint unsigned cycles;
	logic long_hold;
	dir_row_t dir_rows [$];

	windowed_vertex_dedup uut (
		.clk(clk), .arst_n(arst_n),
		.tri_valid(tri_valid), .tri_stall(tri_stall), .tri_data(tri_data),
		.idx_valid(idx_valid), .idx_stall(idx_stall), .idx_data(idx_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Cycle counter and timeout.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("[windowed_vertex_dedup] ERROR");
			$finish;
		end
	end

	// Saturating squared distance between two vertices.
	function automatic logic [63:0] sq_distance(vert_t p, vert_t q);
		logic [64:0] sum;
		logic signed [33:0] d;
		logic [32:0] m;
		logic [65:0] sq;
		sum = '0;
		for (int k = 0; k < 4; k++) begin
			d = 34'(p[k]) - 34'(q[k]);
			m = d < 0 ? 33'(-d) : 33'(d);
			sq = 66'(m) * 66'(m);
			if (sq[65:64] != 0 || 65'(sum) + 65'(sq[63:0]) > 65'(64'hFFFF_FFFF_FFFF_FFFF))
				sum = 65'(64'hFFFF_FFFF_FFFF_FFFF);
			else
				sum = sum + sq[63:0];
		end
		return sum[63:0];
	endfunction

	function automatic vert_t corner_of(tri_t t, int c);
		vert_t v;
		case (c)
			0: v = '{t.a_x, t.a_y, t.a_z, t.a_w};
			1: v = '{t.b_x, t.b_y, t.b_z, t.b_w};
			default: v = '{t.c_x, t.c_y, t.c_z, t.c_w};
		endcase
		return v;
	endfunction

	// Predict the indices for one triangle and update the vertex ring.
	function automatic idx_t weld_triangle(tri_t t);
		vert_t cv [3];
		vert_t sv;
		logic [30:0] ix [3];
		logic hit [3];
		int unsigned n, slot;
		idx_t r;
		for (int c = 0; c < 3; c++) begin
			cv[c] = corner_of(t, c);
			hit[c] = 1'b0;
			ix[c] = '0;
		end
		n = win_reg > DEPTH ? DEPTH : win_reg;
		if (n > vert_count) n = vert_count;
		for (int unsigned s = 0; s < n; s++) begin
			slot = (head_slot + DEPTH - n + s) % DEPTH;
			for (int k = 0; k < 4; k++) sv[k] = ring_mem[slot][k];
			for (int c = 0; c < 3; c++) begin
				if (!hit[c] && sq_distance(cv[c], sv) < {1'b0, thresh_reg}) begin
					hit[c] = 1'b1;
					ix[c] = vert_count - 31'(n) + 31'(s) + 31'd1;
				end
			end
		end
		if (hit[0] && hit[1] && ix[0] == ix[1]) hit[1] = 1'b0;
		if (hit[1] && hit[2] && ix[1] == ix[2]) hit[2] = 1'b0;
		if (hit[0] && hit[2] && ix[0] == ix[2]) hit[2] = 1'b0;
		r = '0;
		for (int c = 0; c < 3; c++) begin
			if (!hit[c]) begin
				r.appended_mask[c] = 1'b1;
				if (vert_count == INDEX_MAX) begin
					ix[c] = INDEX_MAX;
					r.count_overflow = 1'b1;
				end else begin
					for (int k = 0; k < 4; k++) ring_mem[head_slot][k] = cv[c][k];
					head_slot = (head_slot + 1) % DEPTH;
					vert_count = vert_count + 1;
					ix[c] = vert_count;
				end
			end
		end
		r.first_index = ix[0];
		r.second_index = ix[1];
		r.third_index = ix[2];
		return r;
	endfunction

	function automatic tri_t make_tri(vert_t a, vert_t b, vert_t c);
		tri_t t;
		t = {a[0], a[1], a[2], a[3], b[0], b[1], b[2], b[3], c[0], c[1], c[2], c[3]};
		return t;
	endfunction

	function automatic vert_t rand_vert();
		vert_t v;
		for (int k = 0; k < 4; k++) begin
			case ($urandom_range(0, 3))
				0: v[k] = coord_t'($urandom);
				1: v[k] = coord_t'($urandom_range(0, 8)) - 4;
				2: v[k] = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
				default: v[k] = coord_t'($urandom_range(0, 32'h3_0000)) - 32'sh1_8000;
			endcase
		end
		return v;
	endfunction

	// A vertex near one used recently, or now and then a fresh random one, so that merges happen often.
	function automatic vert_t pick_vert();
		vert_t v;
		if (recent_pool.size() == 0 || $urandom_range(0, 3) == 0) begin
			v = rand_vert();
		end else begin
			v = recent_pool[$urandom_range(0, recent_pool.size() - 1)];
			if ($urandom_range(0, 1))
				v[$urandom_range(0, 3)] += coord_t'($urandom_range(0, 4)) - 2;
		end
		recent_pool.insert(recent_pool.size(), v);
		if (recent_pool.size() > 80) void'(recent_pool.pop_front());
		return v;
	endfunction

	// Write one configuration register while the block is idle.
	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [THRESH_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == CFG_WINDOW_SIZE) win_reg = val[6:0];
		else if (idx == CFG_THRESHOLD) thresh_reg = val;
	endtask

	// Offer one request and wait until it is taken.
	task automatic send_tri(tri_t t, logic has_expect, idx_t want);
		idx_t p;
		tri_valid <= 1'b1;
		tri_data <= t;
		@(posedge clk);
		while (tri_stall) @(posedge clk);
		p = weld_triangle(t);
		if (has_expect && p !== want)
			$display("%0t table row disagrees with prediction: exp %h got %h",
				$time, want, p);
		expected_q.insert(expected_q.size(), has_expect ? want : p);
		if (p.appended_mask != 3'b111) merges++;
	endtask

	task automatic drain();
		tri_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (DEPTH + 20) @(posedge clk);
	endtask

	// Receiver: random stall pattern, with one long hold-off on request.
	initial begin
		int run;
		idx_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold) begin
				idx_stall <= 1'b1;
				repeat (400) @(posedge clk);
				idx_stall <= 1'b0;
				long_hold = 1'b0;
			end else if (run > 0) begin
				run--;
			end else begin
				run = $urandom_range(0, 12);
				case ($urandom_range(0, 3))
					0: idx_stall <= 1'b0;
					1: idx_stall <= 1'b1;
					default: idx_stall <= $urandom_range(0, 1);
				endcase
			end
		end
	end

	// Result checker.
	always @(posedge clk) begin
		idx_t e;
		if (arst_n && idx_valid && !idx_stall) begin
			if (expected_q.size() == 0) begin
				$display("%0t unexpected result %h", $time, idx_data);
				errors++;
			end else begin
				e = expected_q.pop_front();
				checked++;
				if (idx_data.first_index !== e.first_index ||
						idx_data.second_index !== e.second_index ||
						idx_data.third_index !== e.third_index ||
						idx_data.appended_mask !== e.appended_mask ||
						idx_data.count_overflow !== e.count_overflow) begin
					$display("%0t mismatch: exp %0d %0d %0d m%b o%b got %0d %0d %0d m%b o%b",
						$time, e.first_index, e.second_index, e.third_index,
						e.appended_mask, e.count_overflow, idx_data.first_index,
						idx_data.second_index, idx_data.third_index,
						idx_data.appended_mask, idx_data.count_overflow);
					errors++;
				end
			end
		end
	end

	function automatic idx_t mk_idx(int f, int s, int t, int m);
		idx_t r;
		r = '{31'(f), 31'(s), 31'(t), 3'(m), 1'b0};
		return r;
	endfunction

	function automatic void add_row(tri_t t, logic he, idx_t w);
		dir_row_t r;
		r.tri_in = t;
		r.has_expect = he;
		r.want = w;
		dir_rows.insert(dir_rows.size(), r);
	endfunction

	initial begin
		vert_t va, vb, vc, vmax, vmin, vzero;
		tri_t t;
		idx_t none;
		int burst;
		arst_n = 1'b0;
		tri_valid = 1'b0;
		tri_data = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_WINDOW_SIZE;
		cfg_data = '0;
		errors = 0;
		checked = 0;
		merges = 0;
		cycles = 0;
		long_hold = 1'b0;
		head_slot = 0;
		vert_count = '0;
		win_reg = 7'd64;
		thresh_reg = 63'd1;
		none = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table, reset configuration: exact match over 64 vertices.
		vmax = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
		vmin = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
		vzero = '{0, 0, 0, 0};
		va = '{32'sh1_0000, 32'sh2_0000, -32'sh3_0000, 32'sh1_0000};
		add_row(make_tri(vmax, vmin, vzero), 1'b1, mk_idx(1, 2, 3, 7));
		// All three corners equal: ties push the second and third out.
		add_row(make_tri(vmax, vmax, vmax), 1'b1, mk_idx(1, 4, 5, 6));
		add_row(make_tri(vzero, vmin, vmax), 1'b1, mk_idx(3, 2, 1, 0));
		// Far extremes: where the distance saturates it never matches.
		add_row(make_tri(va, va, vmin), 1'b0, none);
		add_row(make_tri(vmin, va, vzero), 1'b0, none);
		foreach (dir_rows[i])
			send_tri(dir_rows[i].tri_in, dir_rows[i].has_expect, dir_rows[i].want);
		drain();

		// Zero window: nothing is searched.
		write_reg(CFG_WINDOW_SIZE, 63'd0);
		send_tri(make_tri(vzero, vzero, vzero), 1'b0, none);
		drain();
		// Window above the depth, widest threshold.
		write_reg(CFG_WINDOW_SIZE, 63'd127);
		write_reg(CFG_THRESHOLD, {63{1'b1}});
		send_tri(make_tri(vmax, vmin, va), 1'b0, none);
		send_tri(make_tri(va, vzero, vmax), 1'b0, none);
		drain();
		// Zero threshold: nothing merges.
		write_reg(CFG_THRESHOLD, 63'd0);
		send_tri(make_tri(va, va, va), 1'b0, none);
		drain();
		// Window of one.
		write_reg(CFG_WINDOW_SIZE, 63'd1);
		write_reg(CFG_THRESHOLD, 63'd1);
		send_tri(make_tri(va, va, vzero), 1'b0, none);
		send_tri(make_tri(vzero, va, vzero), 1'b0, none);
		drain();

		// Random phases with several settings.
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin write_reg(CFG_WINDOW_SIZE, 63'd64); write_reg(CFG_THRESHOLD, 63'd1); end
				1: begin write_reg(CFG_WINDOW_SIZE, 63'd8); write_reg(CFG_THRESHOLD, 63'd5); end
				2: begin
					write_reg(CFG_WINDOW_SIZE, 63'($urandom_range(0, 127)));
					write_reg(CFG_THRESHOLD, 63'($urandom_range(0, 200)));
				end
				3: begin write_reg(CFG_WINDOW_SIZE, 63'd64); write_reg(CFG_THRESHOLD, 63'h1_0000_0000); end
				4: begin write_reg(CFG_WINDOW_SIZE, 63'd3); write_reg(CFG_THRESHOLD, 63'd2); end
				default: begin
					write_reg(CFG_WINDOW_SIZE, 63'd100);
					write_reg(CFG_THRESHOLD, {32'($urandom), 31'($urandom)});
				end
			endcase
			for (int i = 0; i < RANDOM_TRIS / 6; ) begin
				burst = $urandom_range(1, 20);
				for (int b = 0; b < burst && i < RANDOM_TRIS / 6; b++, i++) begin
					if (ph == 1 && i == 40) begin
						// Hold the receiver off while requests keep coming.
						long_hold = 1'b1;
					end
					if (ph == 2 && i == 60) begin
						tri_valid <= 1'b0;
						@(posedge clk);
						while (expected_q.size() != 0) @(posedge clk);
					end
					vb = pick_vert();
					vc = pick_vert();
					va = $urandom_range(0, 7) == 0 ? vb : pick_vert();
					send_tri(make_tri(va, vb, vc), 1'b0, none);
				end
				if ($urandom_range(0, 2) != 0) begin
					tri_valid <= 1'b0;
					repeat ($urandom_range(1, 30)) @(posedge clk);
				end
			end
			drain();
		end

		$display("checked %0d results, %0d with merged corners, over %0d cycles",
			checked, merges, cycles);
		if (errors == 0 && expected_q.size() == 0)
			$display("[windowed_vertex_dedup] OK");
		else
			$display("[windowed_vertex_dedup] ERROR");
		$finish;
	end
endmodule

FILE: filelist.f
hdl/wvd_pkg.sv
hdl/wvd_lane.sv
hdl/windowed_vertex_dedup.sv
test/tb.sv
